// ----- sv/krpw_pkg.sv -----
// Shared types, widths and constants of the Kelly risk parity weighting core.
`timescale 1ns / 1ps
package krpw_pkg;

    // Default store depth, in assets.
    localparam int MAX_ASSETS_DEF = 64;

    // Field widths.
    localparam int MU_W    = 32;
    localparam int VOL_W   = 31;
    localparam int CONF_W  = 16;
    localparam int FRAC_W  = 32;
    localparam int CL_W    = 31;
    localparam int SHARE_W = 17;
    localparam int WT_W    = 24;
    localparam int BUD_W   = 32;
    localparam int KS_W    = 16;
    localparam int GE_W    = 24;
    localparam int IDX_W   = 6;

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 160;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    // Shared multiplier and divider widths.
    localparam int MUL_W  = 32;
    localparam int PROD_W = 64;
    localparam int DIV_NW = 73;
    localparam int DIV_DW = 62;
    localparam int DIV_QW = 32;

    // Numerator of the effective asset count, 1.0 in Q25.48.
    localparam logic [DIV_NW-1:0] DN_NUM = DIV_NW'(1) << 48;

    // Register reset values.
    localparam logic [KS_W-1:0]   KS_RST    = 16'd8192;
    localparam logic [CL_W-1:0]   CAP_RST   = 31'd65536;
    localparam logic [CONF_W-1:0] FLOOR_RST = 16'd0;
    localparam logic [GE_W-1:0]   GE_RST    = 24'd65536;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KELLY_SCALE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_CAP = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_FLOOR   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROSS_TARGET = 8'd3;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_MUL_SQ,
        OP_MUL_KM,
        OP_DIV_KELLY,
        OP_RAW,
        OP_MUL_BUD,
        OP_BUD,
        OP_DIV_SHARE,
        OP_SHARE,
        OP_DIV_W,
        OP_WT,
        OP_MUL_WG,
        OP_DIV_F,
        OP_FIN,
        OP_MUL_FF,
        OP_ACC,
        OP_DIV_DN,
        OP_DN,
        OP_OUT_LOAD,
        OP_OUT_ACK
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   accept_en;
        logic   out_valid;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_idx;
    } dp_stat_t;

endpackage

// ----- sv/krpw_ram.sv -----
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module krpw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- sv/krpw_div.sv -----
// Restoring divider, one quotient bit a cycle, quotient saturated to 32 bits.
`timescale 1ns / 1ps
module krpw_div import krpw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic              done,
    output logic [DIV_QW-1:0] quo
);

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        step_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_QW-1:0] quo_reg;
    logic [DIV_DW:0]   trial;
    logic              ge;
    logic              sat;

    // A quotient of 2^32 or more saturates at once.
    assign sat   = {(DIV_DW + DIV_QW - DIV_NW)'(0), num} >= {den, DIV_QW'(0)};
    assign trial = {rem_reg, quo_reg[DIV_QW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    // Control of the iteration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                step_reg <= '0;
                busy_reg <= !sat;
                done_reg <= sat;
            end else if (busy_reg) begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'(DIV_QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift.
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= DIV_DW'(num[DIV_NW-1:DIV_QW]);
            quo_reg <= sat ? '1 : num[DIV_QW-1:0];
        end else if (busy_reg) begin
            rem_reg <= ge ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- sv/krpw_dp.sv -----
// Datapath: asset stores, shared multiplier, divider, accumulators and result register.
`timescale 1ns / 1ps
module krpw_dp import krpw_pkg::*; #(
    parameter int MAX_ASSETS = MAX_ASSETS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  in_fire,
    input  logic                  in_last,
    input  logic [MU_W-1:0]       in_mu,
    input  logic [VOL_W-1:0]      in_vol,
    input  logic [CONF_W-1:0]     in_conf,
    input  logic                  cfg_fire,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [IDX_W-1:0]      o_index,
    output logic [FRAC_W-1:0]     o_raw,
    output logic [CL_W-1:0]       o_clamped,
    output logic [SHARE_W-1:0]    o_share,
    output logic [WT_W-1:0]       o_weight,
    output logic [WT_W-1:0]       o_lev,
    output logic [WT_W-1:0]       o_dn,
    output logic                  o_last
);

    localparam int IW = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
    localparam int CW = $clog2(MAX_ASSETS + 1);
    localparam int TW = BUD_W + $clog2(MAX_ASSETS);
    localparam int LW = WT_W + $clog2(MAX_ASSETS);
    localparam int SW = 2 * WT_W + $clog2(MAX_ASSETS);
    localparam int INW = MU_W + VOL_W + CONF_W;

    // Configuration registers.
    logic [KS_W-1:0]   ks_reg;
    logic [CL_W-1:0]   cap_reg;
    logic [CONF_W-1:0] floor_reg;
    logic [GE_W-1:0]   ge_reg;

    // Run state.
    logic [CW-1:0]      count_reg;
    logic [IW-1:0]      idx_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DIV_DW-1:0]  dsq_reg;
    logic [FRAC_W-1:0]  raw_reg;
    logic [WT_W-1:0]    f_reg;
    logic [SHARE_W-1:0] share_reg;
    logic [TW-1:0]      total_reg;
    logic [TW-1:0]      wsum_reg;
    logic [LW-1:0]      lev_reg;
    logic [SW-1:0]      sq_reg;
    logic [WT_W-1:0]    dn_reg;

    // Store read data.
    logic [INW-1:0]    in_rd;
    logic [FRAC_W-1:0] frac_rd;
    logic [BUD_W-1:0]  bud_rd;
    logic [BUD_W-1:0]  wt_rd;
    logic [MU_W-1:0]   rd_mu;
    logic [VOL_W-1:0]  rd_vol;
    logic [CONF_W-1:0] rd_conf;

    // Working values.
    logic              last_idx;
    logic              in_we;
    logic              neg;
    logic [MU_W-1:0]   mag;
    logic [DIV_QW-1:0] lim;
    logic [DIV_QW-1:0] magc;
    logic [FRAC_W-1:0] raw_c;
    logic [CL_W-1:0]   cl_c;
    logic [BUD_W-1:0]  budget_c;
    logic [SHARE_W-1:0] share_c;
    logic [BUD_W-1:0]  w_c;
    logic [WT_W-1:0]   f_c;
    logic [WT_W-1:0]   dn_c;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic              mul_en;
    logic              div_start;
    logic [DIV_NW-1:0] div_n;
    logic [DIV_DW-1:0] div_d;
    logic              div_done;
    logic [DIV_QW-1:0] div_q;
    logic              frac_we;
    logic              bud_we;
    logic [BUD_W-1:0]  bud_wd;
    logic              wt_we;
    logic [BUD_W-1:0]  wt_wd;

    // Raw fraction clamped to zero and the cap.
    function automatic logic [CL_W-1:0] clamp_frac(input logic [FRAC_W-1:0] raw,
                                                   input logic [CL_W-1:0] cap);
        if (raw[FRAC_W-1]) begin
            return '0;
        end
        return (raw[CL_W-1:0] < cap) ? raw[CL_W-1:0] : cap;
    endfunction

    assign last_idx = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign in_we    = in_fire && (count_reg < CW'(MAX_ASSETS));
    assign stat     = '{div_done: div_done, last_idx: last_idx};

    assign rd_mu   = in_rd[MU_W-1:0];
    assign rd_vol  = in_rd[MU_W+VOL_W-1:MU_W];
    assign rd_conf = in_rd[INW-1:MU_W+VOL_W];

    // Kelly value from the saturated quotient; zero volatility gives zero.
    always_comb begin
        neg   = rd_mu[MU_W-1];
        mag   = neg ? (~rd_mu + MU_W'(1)) : rd_mu;
        lim   = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        magc  = (div_q > lim) ? lim : div_q;
        raw_c = (rd_vol == '0) ? '0 : (neg ? (FRAC_W'(0) - magc) : magc);
    end

    // Budget, share, weight and effective count terms.
    always_comb begin
        cl_c     = clamp_frac(raw_reg, cap_reg);
        budget_c = (rd_conf < floor_reg) ? '0 : prod_reg[46:15];
        share_c  = (total_reg == '0) ? '0 : div_q[SHARE_W-1:0];
        w_c      = ((rd_vol != '0) && (share_reg != '0)) ? div_q : '0;
        f_c      = (wsum_reg == '0) ? '0 : div_q[WT_W-1:0];
        if (sq_reg == '0) begin
            dn_c = '0;
        end else begin
            dn_c = (div_q > 32'h00FF_FFFF) ? '1 : div_q[WT_W-1:0];
        end
    end

    // Operand selection of the shared multiplier.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_MUL_SQ: begin
                mul_a = MUL_W'(rd_vol);
                mul_b = MUL_W'(rd_vol);
            end
            OP_MUL_KM: begin
                mul_a = mag;
                mul_b = MUL_W'(ks_reg);
            end
            OP_MUL_BUD: begin
                mul_a = MUL_W'(cl_c);
                mul_b = MUL_W'(rd_conf);
            end
            OP_MUL_WG: begin
                mul_a = wt_rd;
                mul_b = MUL_W'(ge_reg);
            end
            OP_MUL_FF: begin
                mul_a = MUL_W'(f_reg);
                mul_b = MUL_W'(f_reg);
            end
            default: mul_en = 1'b0;
        endcase
    end

    // Operand selection of the divider.
    always_comb begin
        div_n     = '0;
        div_d     = '0;
        div_start = 1'b1;
        case (cmd.op)
            OP_DIV_KELLY: begin
                div_n = {prod_reg[47:0], 25'd0};
                div_d = dsq_reg;
            end
            OP_DIV_SHARE: begin
                div_n = DIV_NW'({bud_rd, 16'd0});
                div_d = DIV_DW'(total_reg);
            end
            OP_DIV_W: begin
                div_n = DIV_NW'({share_reg, 24'd0});
                div_d = DIV_DW'(rd_vol);
            end
            OP_DIV_F: begin
                div_n = DIV_NW'(prod_reg[55:0]);
                div_d = DIV_DW'(wsum_reg);
            end
            OP_DIV_DN: begin
                div_n = DN_NUM;
                div_d = DIV_DW'(sq_reg);
            end
            default: div_start = 1'b0;
        endcase
    end

    // Store write ports.
    assign frac_we = cmd.op == OP_RAW;
    assign bud_we  = (cmd.op == OP_BUD) || (cmd.op == OP_SHARE);
    assign bud_wd  = (cmd.op == OP_BUD) ? budget_c : BUD_W'(share_c);
    assign wt_we   = (cmd.op == OP_WT) || (cmd.op == OP_FIN);
    assign wt_wd   = (cmd.op == OP_WT) ? w_c : BUD_W'(f_c);

    krpw_ram #(.WIDTH(INW), .DEPTH(MAX_ASSETS)) u_in_ram (
        .aclk  (aclk),
        .we    (in_we),
        .waddr (count_reg[IW-1:0]),
        .wdata ({in_conf, in_vol, in_mu}),
        .raddr (idx_reg),
        .rdata (in_rd)
    );

    krpw_ram #(.WIDTH(FRAC_W), .DEPTH(MAX_ASSETS)) u_frac_ram (
        .aclk  (aclk),
        .we    (frac_we),
        .waddr (idx_reg),
        .wdata (raw_c),
        .raddr (idx_reg),
        .rdata (frac_rd)
    );

    krpw_ram #(.WIDTH(BUD_W), .DEPTH(MAX_ASSETS)) u_bud_ram (
        .aclk  (aclk),
        .we    (bud_we),
        .waddr (idx_reg),
        .wdata (bud_wd),
        .raddr (idx_reg),
        .rdata (bud_rd)
    );

    krpw_ram #(.WIDTH(BUD_W), .DEPTH(MAX_ASSETS)) u_wt_ram (
        .aclk  (aclk),
        .we    (wt_we),
        .waddr (idx_reg),
        .wdata (wt_wd),
        .raddr (idx_reg),
        .rdata (wt_rd)
    );

    krpw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_n),
        .den     (div_d),
        .done    (div_done),
        .quo     (div_q)
    );

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ks_reg    <= KS_RST;
            cap_reg   <= CAP_RST;
            floor_reg <= FLOOR_RST;
            ge_reg    <= GE_RST;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                CFG_KELLY_SCALE:  ks_reg    <= cfg_data[KS_W-1:0];
                CFG_FRACTION_CAP: cap_reg   <= cfg_data[CL_W-1:0];
                CFG_CONF_FLOOR:   floor_reg <= cfg_data[CONF_W-1:0];
                CFG_GROSS_TARGET: ge_reg    <= cfg_data[GE_W-1:0];
                default: ;
            endcase
        end
    end

    // Asset count and walk index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            if (in_we) begin
                count_reg <= count_reg + CW'(1);
            end
            if (in_fire && in_last) begin
                idx_reg <= '0;
            end
            if ((cmd.op == OP_BUD) || (cmd.op == OP_WT) || (cmd.op == OP_ACC) ||
                (cmd.op == OP_OUT_ACK)) begin
                idx_reg <= last_idx ? '0 : idx_reg + IW'(1);
            end
            if ((cmd.op == OP_OUT_ACK) && last_idx) begin
                count_reg <= '0;
            end
        end
    end

    // Product register of the shared multiplier.
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.op == OP_MUL_KM) begin
            dsq_reg <= prod_reg[DIV_DW-1:0];
        end
    end

    // Per-asset terms and run accumulators.
    always_ff @(posedge aclk) begin
        if (in_fire && in_last) begin
            total_reg <= '0;
            wsum_reg  <= '0;
            lev_reg   <= '0;
            sq_reg    <= '0;
        end
        case (cmd.op)
            OP_RAW:   raw_reg   <= raw_c;
            OP_BUD:   total_reg <= total_reg + TW'(budget_c);
            OP_SHARE: share_reg <= share_c;
            OP_WT:    wsum_reg  <= wsum_reg + TW'(w_c);
            OP_FIN: begin
                f_reg   <= f_c;
                lev_reg <= lev_reg + LW'(f_c);
            end
            OP_ACC:   sq_reg    <= sq_reg + SW'(prod_reg[47:0]);
            OP_DN:    dn_reg    <= dn_c;
            default: ;
        endcase
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUT_LOAD) begin
            o_index   <= IDX_W'(idx_reg);
            o_raw     <= frac_rd;
            o_clamped <= clamp_frac(frac_rd, cap_reg);
            o_share   <= bud_rd[SHARE_W-1:0];
            o_weight  <= wt_rd[WT_W-1:0];
            o_last    <= last_idx;
            if (last_idx) begin
                o_lev <= (lev_reg > LW'(24'hFF_FFFF)) ? '1 : lev_reg[WT_W-1:0];
                o_dn  <= dn_reg;
            end else begin
                o_lev <= '0;
                o_dn  <= '0;
            end
        end
    end

endmodule

// ----- sv/krpw_ctrl.sv -----
// Controller: sequences load, the three passes over the stores and the result walk.
`timescale 1ns / 1ps
module krpw_ctrl import krpw_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_fire,
    input  logic     in_last,
    input  logic     out_fire,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [28:0] {
        ST_IDLE   = 29'(1) << 0,
        ST_K_WAIT = 29'(1) << 1,
        ST_K_SQ   = 29'(1) << 2,
        ST_K_KM   = 29'(1) << 3,
        ST_K_DS   = 29'(1) << 4,
        ST_K_DW   = 29'(1) << 5,
        ST_K_RAW  = 29'(1) << 6,
        ST_K_BM   = 29'(1) << 7,
        ST_K_BUD  = 29'(1) << 8,
        ST_N_WAIT = 29'(1) << 9,
        ST_N_DS   = 29'(1) << 10,
        ST_N_DW   = 29'(1) << 11,
        ST_N_SH   = 29'(1) << 12,
        ST_N_WS   = 29'(1) << 13,
        ST_N_WW   = 29'(1) << 14,
        ST_N_W    = 29'(1) << 15,
        ST_G_WAIT = 29'(1) << 16,
        ST_G_M    = 29'(1) << 17,
        ST_G_DS   = 29'(1) << 18,
        ST_G_DW   = 29'(1) << 19,
        ST_G_F    = 29'(1) << 20,
        ST_G_SQ   = 29'(1) << 21,
        ST_G_ACC  = 29'(1) << 22,
        ST_D_DS   = 29'(1) << 23,
        ST_D_DW   = 29'(1) << 24,
        ST_D_FIN  = 29'(1) << 25,
        ST_O_WAIT = 29'(1) << 26,
        ST_O_LOAD = 29'(1) << 27,
        ST_O_HOLD = 29'(1) << 28
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command.
    always_comb begin
        state_next    = state_reg;
        cmd.op        = OP_NOP;
        cmd.accept_en = 1'b0;
        cmd.out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept_en = 1'b1;
                if (in_fire && in_last) begin
                    state_next = ST_K_WAIT;
                end
            end
            // Kelly fraction and raw budget of each asset.
            ST_K_WAIT: state_next = ST_K_SQ;
            ST_K_SQ: begin
                cmd.op     = OP_MUL_SQ;
                state_next = ST_K_KM;
            end
            ST_K_KM: begin
                cmd.op     = OP_MUL_KM;
                state_next = ST_K_DS;
            end
            ST_K_DS: begin
                cmd.op     = OP_DIV_KELLY;
                state_next = ST_K_DW;
            end
            ST_K_DW: begin
                if (stat.div_done) begin
                    state_next = ST_K_RAW;
                end
            end
            ST_K_RAW: begin
                cmd.op     = OP_RAW;
                state_next = ST_K_BM;
            end
            ST_K_BM: begin
                cmd.op     = OP_MUL_BUD;
                state_next = ST_K_BUD;
            end
            ST_K_BUD: begin
                cmd.op     = OP_BUD;
                state_next = stat.last_idx ? ST_N_WAIT : ST_K_WAIT;
            end
            // Normalised share and unscaled weight.
            ST_N_WAIT: state_next = ST_N_DS;
            ST_N_DS: begin
                cmd.op     = OP_DIV_SHARE;
                state_next = ST_N_DW;
            end
            ST_N_DW: begin
                if (stat.div_done) begin
                    state_next = ST_N_SH;
                end
            end
            ST_N_SH: begin
                cmd.op     = OP_SHARE;
                state_next = ST_N_WS;
            end
            ST_N_WS: begin
                cmd.op     = OP_DIV_W;
                state_next = ST_N_WW;
            end
            ST_N_WW: begin
                if (stat.div_done) begin
                    state_next = ST_N_W;
                end
            end
            ST_N_W: begin
                cmd.op     = OP_WT;
                state_next = stat.last_idx ? ST_G_WAIT : ST_N_WAIT;
            end
            // Scaling to the exposure target.
            ST_G_WAIT: state_next = ST_G_M;
            ST_G_M: begin
                cmd.op     = OP_MUL_WG;
                state_next = ST_G_DS;
            end
            ST_G_DS: begin
                cmd.op     = OP_DIV_F;
                state_next = ST_G_DW;
            end
            ST_G_DW: begin
                if (stat.div_done) begin
                    state_next = ST_G_F;
                end
            end
            ST_G_F: begin
                cmd.op     = OP_FIN;
                state_next = ST_G_SQ;
            end
            ST_G_SQ: begin
                cmd.op     = OP_MUL_FF;
                state_next = ST_G_ACC;
            end
            ST_G_ACC: begin
                cmd.op     = OP_ACC;
                state_next = stat.last_idx ? ST_D_DS : ST_G_WAIT;
            end
            // Effective asset count.
            ST_D_DS: begin
                cmd.op     = OP_DIV_DN;
                state_next = ST_D_DW;
            end
            ST_D_DW: begin
                if (stat.div_done) begin
                    state_next = ST_D_FIN;
                end
            end
            ST_D_FIN: begin
                cmd.op     = OP_DN;
                state_next = ST_O_WAIT;
            end
            // Result walk in load order.
            ST_O_WAIT: state_next = ST_O_LOAD;
            ST_O_LOAD: begin
                cmd.op     = OP_OUT_LOAD;
                state_next = ST_O_HOLD;
            end
            ST_O_HOLD: begin
                cmd.out_valid = 1'b1;
                if (out_fire) begin
                    cmd.op     = OP_OUT_ACK;
                    state_next = stat.last_idx ? ST_IDLE : ST_O_WAIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/kelly_risk_parity_weights_core.sv -----
// Top level of the fractional Kelly risk parity weighting core.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_tvalid / s_tready  s_tdata (mu, sigma, confidence), s_tlast
//  m_       out        m_tvalid / m_tready  m_tdata (seven result fields), m_tlast
//  cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Loading takes one item per cycle. The item with s_tlast starts a run over the
// stored assets and then the final count, paced by the shared 32-step divider, used
// four times per asset; a saturating quotient skips the steps. Results then leave
// one at a time in load order, the next loaded only after the last is taken.
// Reset is synchronous on aresetn low and empties the store; no input item is
// taken while a run is in progress, and a stalled result simply holds the walk.
`timescale 1ns / 1ps
module kelly_risk_parity_weights_core import krpw_pkg::*; #(
    parameter int MAX_ASSETS = MAX_ASSETS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // expected_return [31:0], volatility [62:32], signal_confidence [78:63]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // asset_index [5:0], raw_fraction [37:6], clamped_fraction [68:38],
    // budget_share [85:69], final_weight [109:86], leverage_sum [133:110],
    // diversification_count [157:134]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic               in_fire;
    logic               out_fire;
    logic [IDX_W-1:0]   o_index;
    logic [FRAC_W-1:0]  o_raw;
    logic [CL_W-1:0]    o_clamped;
    logic [SHARE_W-1:0] o_share;
    logic [WT_W-1:0]    o_weight;
    logic [WT_W-1:0]    o_lev;
    logic [WT_W-1:0]    o_dn;

    // Handshakes.
    assign s_tready  = cmd.accept_en;
    assign m_tvalid  = cmd.out_valid;
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;

    krpw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_last  (s_tlast),
        .out_fire (out_fire),
        .stat     (stat),
        .cmd      (cmd)
    );

    krpw_dp #(.MAX_ASSETS(MAX_ASSETS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_fire   (in_fire),
        .in_last   (s_tlast),
        .in_mu     (s_tdata[MU_W-1:0]),
        .in_vol    (s_tdata[MU_W+VOL_W-1:MU_W]),
        .in_conf   (s_tdata[MU_W+VOL_W+CONF_W-1:MU_W+VOL_W]),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .o_index   (o_index),
        .o_raw     (o_raw),
        .o_clamped (o_clamped),
        .o_share   (o_share),
        .o_weight  (o_weight),
        .o_lev     (o_lev),
        .o_dn      (o_dn),
        .o_last    (m_tlast)
    );

    // Result packing, first field lowest.
    assign m_tdata = {2'b00, o_dn, o_lev, o_weight, o_share, o_clamped, o_raw, o_index};

`ifndef SYNTH
    // Loading and the result walk never overlap.
    assert property (@(posedge aclk) disable iff (!aresetn) !(m_tvalid && s_tready))
        else $error("input accepted while a result is offered");

    // The divider only finishes while the controller waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (cmd.op == OP_NOP) && !cmd.accept_en && !cmd.out_valid)
        else $error("divider result arrived outside a wait state");

    // Taking the last result returns the block to loading.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not ready for loading after the last result");
`endif

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the Kelly risk parity weighting core.
`timescale 1ns / 1ps
module tb;
    import krpw_pkg::*;

    // One asset item as offered on the input stream.
    typedef struct {
        logic [MU_W-1:0]   mu;
        logic [VOL_W-1:0]  vol;
        logic [CONF_W-1:0] conf;
        logic              last;
    } asset_item_t;

    // One predicted result item.
    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [FRAC_W-1:0]  raw;
        logic [CL_W-1:0]    clamped;
        logic [SHARE_W-1:0] share;
        logic [WT_W-1:0]    weight;
        logic [WT_W-1:0]    leverage;
        logic [WT_W-1:0]    eff_n;
        logic               last;
    } weight_result_t;

    localparam int WATCHDOG_LIMIT = 60000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    kelly_risk_parity_weights_core u_top (.*);

    // Clock: 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor state: register copies and the asset store.
    logic [KS_W-1:0]   kelly_scale_r = KS_RST;
    logic [CL_W-1:0]   cap_r = CAP_RST;
    logic [CONF_W-1:0] floor_r = FLOOR_RST;
    logic [GE_W-1:0]   gross_r = GE_RST;
    logic [MU_W-1:0]   mu_store [64];
    logic [VOL_W-1:0]  vol_store [64];
    logic [CONF_W-1:0] conf_store [64];
    int unsigned       stored_assets = 0;

    asset_item_t    pending_assets [$];
    weight_result_t expected_weights [$];

    int unsigned items_accepted = 0, results_seen = 0, sets_run = 0, cfg_writes = 0;
    int unsigned mismatches = 0;
    bit          no_idle = 1'b0;
    int unsigned quiet_cycles = 0;

    // Fractional Kelly value as Q16.16, truncated toward zero and saturated.
    function automatic logic [FRAC_W-1:0] kelly_q16_value(logic [MU_W-1:0] mu,
                                                          logic [VOL_W-1:0] sig);
        logic [72:0] mag, num, den, quo, lim;
        logic neg;
        neg = mu[31];
        if (sig == 0)
            return '0;
        mag = neg ? 73'(32'(~mu + 32'd1)) : 73'(mu);
        num = mag * 73'(kelly_scale_r);
        den = 73'(sig) * 73'(sig);
        lim = neg ? 73'h8000_0000 : 73'h7FFF_FFFF;
        if (num / den >= 64) begin
            quo = lim;
        end else begin
            quo = (num << 25) / den;
            if (quo > lim)
                quo = lim;
        end
        return neg ? 32'(32'd0 - quo[31:0]) : quo[31:0];
    endfunction

    function automatic logic [CL_W-1:0] clamp_to_cap(logic [FRAC_W-1:0] raw);
        if (raw[31])
            return '0;
        return (raw[30:0] < cap_r) ? raw[30:0] : cap_r;
    endfunction

    // Store an accepted asset; on the last flag compute the whole set.
    task automatic predict_asset_item(asset_item_t it);
        logic [FRAC_W-1:0] raw [64];
        logic [63:0] budget [64];
        logic [63:0] share [64];
        logic [63:0] w [64];
        logic [63:0] fin [64];
        logic [63:0] total, wsum, lev, sq, dn;
        weight_result_t r;
        int unsigned n;
        if (stored_assets < 64) begin
            mu_store[stored_assets] = it.mu;
            vol_store[stored_assets] = it.vol;
            conf_store[stored_assets] = it.conf;
            stored_assets++;
        end
        if (!it.last)
            return;
        n = stored_assets;
        total = 0;
        for (int i = 0; i < n; i++) begin
            raw[i] = kelly_q16_value(mu_store[i], vol_store[i]);
            if (conf_store[i] < floor_r)
                budget[i] = 0;
            else
                budget[i] = (64'(clamp_to_cap(raw[i])) * 64'(conf_store[i])) >> 15;
            total += budget[i];
        end
        wsum = 0;
        for (int i = 0; i < n; i++) begin
            share[i] = (total != 0) ? (budget[i] << 16) / total : 0;
            w[i] = 0;
            if (vol_store[i] != 0 && share[i] != 0) begin
                w[i] = (share[i] << 24) / 64'(vol_store[i]);
                if (w[i] > 64'hFFFF_FFFF)
                    w[i] = 64'hFFFF_FFFF;
            end
            wsum += w[i];
        end
        lev = 0;
        sq = 0;
        for (int i = 0; i < n; i++) begin
            fin[i] = (wsum != 0) ? (w[i] * 64'(gross_r)) / wsum : 0;
            lev += fin[i];
            sq += fin[i] * fin[i];
        end
        if (lev > 64'hFF_FFFF)
            lev = 64'hFF_FFFF;
        dn = 0;
        if (sq != 0) begin
            dn = (64'd1 << 48) / sq;
            if (dn > 64'hFF_FFFF)
                dn = 64'hFF_FFFF;
        end
        for (int i = 0; i < n; i++) begin
            r.idx = IDX_W'(i);
            r.raw = raw[i];
            r.clamped = clamp_to_cap(raw[i]);
            r.share = share[i][SHARE_W-1:0];
            r.weight = fin[i][WT_W-1:0];
            r.last = (i + 1 == n);
            r.leverage = r.last ? lev[WT_W-1:0] : '0;
            r.eff_n = r.last ? dn[WT_W-1:0] : '0;
            expected_weights.push_back(r);
        end
        stored_assets = 0;
        sets_run++;
    endtask

    // Input driver: presents queued assets with random gaps.
    int unsigned send_gap = 0;
    always @(posedge aclk) begin
        asset_item_t it;
        logic accepted;
        if (aresetn) begin
            accepted = s_tvalid && s_tready;
            if (accepted) begin
                it.mu = s_tdata[31:0];
                it.vol = s_tdata[62:32];
                it.conf = s_tdata[78:63];
                it.last = s_tlast;
                predict_asset_item(it);
                items_accepted++;
                send_gap = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (!s_tvalid || accepted) begin
                if (send_gap > 0 || pending_assets.size() == 0) begin
                    if (send_gap > 0)
                        send_gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    it = pending_assets.pop_front();
                    s_tdata <= {1'b0, it.conf, it.vol, it.mu};
                    s_tlast <= it.last;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // Result monitor: checks each result item and paces m_tready.
    int unsigned recv_gap = 0, hold_off = 0;
    bit          hold_done = 1'b0;
    always @(posedge aclk) begin
        weight_result_t exp_r;
        weight_result_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.idx = m_tdata[5:0];
                got.raw = m_tdata[37:6];
                got.clamped = m_tdata[68:38];
                got.share = m_tdata[85:69];
                got.weight = m_tdata[109:86];
                got.leverage = m_tdata[133:110];
                got.eff_n = m_tdata[157:134];
                got.last = m_tlast;
                if (expected_weights.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result item, asset %0d", got.idx);
                end else begin
                    exp_r = expected_weights.pop_front();
                    if (got.idx !== exp_r.idx || got.raw !== exp_r.raw
                        || got.clamped !== exp_r.clamped || got.share !== exp_r.share
                        || got.weight !== exp_r.weight || got.leverage !== exp_r.leverage
                        || got.eff_n !== exp_r.eff_n || got.last !== exp_r.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR: result mismatch at asset %0d", exp_r.idx);
                            $display("  expected idx %0d raw %h cl %h share %h wt %h lev %h dn %h last %b",
                                exp_r.idx, exp_r.raw, exp_r.clamped, exp_r.share,
                                exp_r.weight, exp_r.leverage, exp_r.eff_n, exp_r.last);
                            $display("  actual   idx %0d raw %h cl %h share %h wt %h lev %h dn %h last %b",
                                got.idx, got.raw, got.clamped, got.share,
                                got.weight, got.leverage, got.eff_n, got.last);
                        end
                    end
                end
                recv_gap = no_idle ? 0 : $urandom_range(0, 9);
                // One long hold-off while the sender keeps offering assets.
                if (!hold_done && pending_assets.size() != 0) begin
                    hold_done = 1'b1;
                    hold_off = 3000;
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake of any kind.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Register write through the configuration channel.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            CFG_KELLY_SCALE:  kelly_scale_r = value[KS_W-1:0];
            CFG_FRACTION_CAP: cap_r = value[CL_W-1:0];
            CFG_CONF_FLOOR:   floor_r = value[CONF_W-1:0];
            CFG_GROSS_TARGET: gross_r = value[GE_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_registers(int unsigned ks, int unsigned cap, int unsigned fl,
                                 int unsigned ge);
        write_register(CFG_KELLY_SCALE, ks);
        write_register(CFG_FRACTION_CAP, cap);
        write_register(CFG_CONF_FLOOR, fl);
        write_register(CFG_GROSS_TARGET, ge);
    endtask

    // Wait until every queued asset is taken and every result is back.
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_assets.size() != 0 || s_tvalid || expected_weights.size() != 0);
        repeat (60) @(posedge aclk);
    endtask

    task automatic push_asset(logic [31:0] mu, logic [30:0] vol, logic [15:0] conf, bit last);
        asset_item_t it;
        it.mu = mu;
        it.vol = vol;
        it.conf = conf;
        it.last = last;
        pending_assets.push_back(it);
    endtask

    // Random set of well-formed assets, with the odd degenerate member.
    task automatic push_random_set(int unsigned n);
        logic [30:0] vol;
        logic [15:0] conf;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:       vol = 31'($urandom);
                1:       vol = '0;
                2:       vol = 31'($urandom_range(1, 255));
                default: vol = 31'($urandom_range(1 << 20, 1 << 26));
            endcase
            conf = ($urandom_range(0, 3) == 0) ? 16'd32768 : 16'($urandom);
            push_asset($urandom, vol, conf, i == n - 1);
        end
    endtask

    // Stimulus sequence.
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: default registers, field extremes and special cases.
        push_asset(32'h7FFF_FFFF, 31'd1 << 24, 16'd32768, 1'b1);
        push_asset(32'h8000_0000, 31'd1, 16'hFFFF, 1'b0);
        push_asset(32'h0000_0000, 31'h7FFF_FFFF, 16'd0, 1'b0);
        push_asset(32'h0100_0000, 31'd0, 16'd32768, 1'b0);
        push_asset(32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 1'b0);
        push_asset(32'h0040_0000, 31'd1 << 22, 16'd32768, 1'b1);
        // Every budget zero: only negative returns.
        push_asset(32'hFF00_0000, 31'd1 << 23, 16'd32768, 1'b0);
        push_asset(32'hFFFF_FFFF, 31'd1 << 24, 16'd16384, 1'b1);
        wait_idle();

        // Extremes of the registers, then a store overflow.
        set_registers(32768, 32'h7FFF_FFFF, 0, 24'hFF_FFFF);
        push_random_set(5);
        for (int i = 0; i < 68; i++)
            push_asset(32'($urandom_range(1 << 20, 1 << 24)), 31'($urandom_range(1 << 22, 1 << 25)),
                       16'd32768, i == 67);
        wait_idle();
        set_registers(0, 0, 16'hFFFF, 0);
        push_random_set(4);
        wait_idle();
        // Confidence floor in the middle of the range.
        set_registers(16384, 131072, 20000, 65536 * 3);
        push_random_set(6);
        wait_idle();

        // Random phases with random register settings.
        for (int ph = 0; ph < 6; ph++) begin
            set_registers($urandom_range(0, 32768), $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 14),
                          ($urandom_range(0, 1) == 1) ? $urandom_range(0, 65535) : 0,
                          $urandom_range(0, 24'hFF_FFFF));
            no_idle = (ph % 3 == 2);
            for (int s = 0; s < 10; s++)
                push_random_set(($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                             : $urandom_range(1, 6));
            wait_idle();
        end

        $display("Run covered %0d asset items in %0d sets, %0d result items, %0d register writes.",
                 items_accepted, sets_run, results_seen, cfg_writes);
        $display("Mismatches found: %0d", mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/krpw_pkg.sv
sv/krpw_ram.sv
sv/krpw_div.sv
sv/krpw_dp.sv
sv/krpw_ctrl.sv
sv/kelly_risk_parity_weights_core.sv
dv/tb.sv
